// ----- rtl/bdxf_pkg.sv -----
// ----------------------------------------------------------------------------
// Binary DXF pair decoder package
// Shared types, result codes and the signature table of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bdxf_pkg;

    // Signature length, the final nul included.
    localparam int unsigned SigLen = 22;

    // Value kinds of a result beat.
    localparam logic [2:0] KIND_TEXT = 3'd0;
    localparam logic [2:0] KIND_TEND = 3'd1;
    localparam logic [2:0] KIND_FLT  = 3'd2;
    localparam logic [2:0] KIND_I16  = 3'd3;
    localparam logic [2:0] KIND_I32  = 3'd4;
    localparam logic [2:0] KIND_I64  = 3'd5;
    localparam logic [2:0] KIND_STAT = 3'd6;

    // Status codes of a result beat.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_BIN  = 3'd1;
    localparam logic [2:0] ST_UNKNOWN  = 3'd2;
    localparam logic [2:0] ST_TRUNC    = 3'd3;
    localparam logic [2:0] ST_UNTERM   = 3'd4;

    // Decoder phases.
    typedef enum logic [2:0] {
        PH_SIG   = 3'd0,
        PH_CLO   = 3'd1,
        PH_CHI   = 3'd2,
        PH_TEXT  = 3'd3,
        PH_NUM   = 3'd4,
        PH_DRAIN = 3'd5
    } t_phase;

    // One result beat.
    typedef struct packed {
        logic signed [15:0] group_code;
        logic [2:0]         value_kind;
        logic [63:0]        value_bits;
        logic [7:0]         text_byte;
        logic               pair_done;
        logic [2:0]         status;
        logic               stream_end;
    } t_result;

    // Expected signature byte at a given position.
    function automatic logic [7:0] sig_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'h41;
            5'd1:    b = 8'h75;
            5'd2:    b = 8'h74;
            5'd3:    b = 8'h6F;
            5'd4:    b = 8'h43;
            5'd5:    b = 8'h41;
            5'd6:    b = 8'h44;
            5'd7:    b = 8'h20;
            5'd8:    b = 8'h42;
            5'd9:    b = 8'h69;
            5'd10:   b = 8'h6E;
            5'd11:   b = 8'h61;
            5'd12:   b = 8'h72;
            5'd13:   b = 8'h79;
            5'd14:   b = 8'h20;
            5'd15:   b = 8'h44;
            5'd16:   b = 8'h58;
            5'd17:   b = 8'h46;
            5'd18:   b = 8'h0D;
            5'd19:   b = 8'h0A;
            5'd20:   b = 8'h1A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Number of value bytes for a numeric kind.
    function automatic logic [3:0] kind_len(input logic [2:0] kind);
        logic [3:0] n;
        case (kind)
            KIND_I16: n = 4'd2;
            KIND_I32: n = 4'd4;
            default:  n = 4'd8;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bdxf_in_if.sv -----
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel carrying one file byte and its end-of-file flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdxf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// ----- rtl/bdxf_out_if.sv -----
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one decoded result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdxf_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] group_code;
    logic [2:0]         value_kind;
    logic [63:0]        value_bits;
    logic [7:0]         text_byte;
    logic               pair_done;
    logic [2:0]         status;
    logic               stream_end;

    modport source (
        output valid, output group_code, output value_kind, output value_bits,
        output text_byte, output pair_done, output status, output stream_end,
        input ready
    );
    modport sink (
        input valid, input group_code, input value_kind, input value_bits,
        input text_byte, input pair_done, input status, input stream_end,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/binary_dxf_pair_decoder.sv -----
// ----------------------------------------------------------------------------
// Binary DXF pair decoder
// Checks the binary signature, then decodes group code / value pairs from a
// byte stream into text bytes, numbers and status beats.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat
//  i_in      in         one file byte, end_of_input on the last byte
//  o_out     out        zero or one result beat per input beat
//
//  One byte per cycle while the output is not stalled; a byte's result is loaded
//  into the result register when the byte moves on from the input register.
//  Reset clears the decoder to signature matching and empties both registers.
//  A stalled output holds the result register; the input register still takes
//  a beat if it is empty, so the byte path stops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_dxf_pair_decoder (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bdxf_in_if.sink     i_in,
    bdxf_out_if.source  o_out
);
    import bdxf_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_eoi;
    logic       r_out_valid;
    t_result    r_out;

    logic       adv;
    t_result    res;
    logic       res_valid;

    // The held byte moves on when the result register is free or draining.
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.in_byte;
            r_eoi  <= i_in.end_of_input;
        end
    end

    bdxf_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_byte      (r_byte),
        .i_eoi       (r_eoi),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.group_code = r_out.group_code;
    assign o_out.value_kind = r_out.value_kind;
    assign o_out.value_bits = r_out.value_bits;
    assign o_out.text_byte  = r_out.text_byte;
    assign o_out.pair_done  = r_out.pair_done;
    assign o_out.status     = r_out.status;
    assign o_out.stream_end = r_out.stream_end;

endmodule

`default_nettype wire

// ----- rtl/bdxf_classify.sv -----
// ----------------------------------------------------------------------------
// Group code classifier
// Maps a signed group code to its value kind by code range.
// ----------------------------------------------------------------------------
`default_nettype none

module bdxf_classify (
    input  wire logic [15:0] i_code,
    output logic [2:0]       o_kind
);
    import bdxf_pkg::*;

    logic signed [15:0] code_s;

    assign code_s = $signed(i_code);

    // Range tests in priority order; anything left over is unknown.
    always_comb begin
        if (code_s inside {[16'sd0:16'sd9], [16'sd300:16'sd309], [16'sd100:16'sd102],
                           16'sd105, [16'sd350:16'sd369], [16'sd390:16'sd399]}) begin
            o_kind = KIND_TEXT;
        end else if (code_s inside {[16'sd10:16'sd59], [16'sd110:16'sd149],
                                    [16'sd210:16'sd239]}) begin
            o_kind = KIND_FLT;
        end else if (code_s inside {[16'sd60:16'sd79], [16'sd170:16'sd179]}) begin
            o_kind = KIND_I16;
        end else if (code_s inside {[16'sd90:16'sd99], [16'sd370:16'sd389]}) begin
            o_kind = KIND_I32;
        end else if (code_s inside {[16'sd160:16'sd169]}) begin
            o_kind = KIND_I64;
        end else begin
            o_kind = KIND_STAT;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bdxf_step.sv -----
// ----------------------------------------------------------------------------
// Decoder step
// Holds the decoder state and works out, for one byte, the next state and
// the result beat that the byte causes, if any.
// ----------------------------------------------------------------------------
`default_nettype none

module bdxf_step (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_eoi,
    output bdxf_pkg::t_result  o_res,
    output logic               o_res_valid
);
    import bdxf_pkg::*;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_sig_idx, n_sig_idx;
    logic [15:0] r_code, n_code;
    logic [63:0] r_shift, n_shift;
    logic [3:0]  r_left, n_left;
    logic [2:0]  r_pend, n_pend;

    logic [15:0] code_full;
    logic [2:0]  code_kind;
    logic [4:0]  sig_pos;
    logic [4:0]  sig_next;
    logic [63:0] shift_in;
    logic [3:0]  left_dec;
    logic [2:0]  num_kind;
    logic [63:0] num_val;

    assign code_full = {i_byte, r_code[7:0]};

    bdxf_classify u_classify (
        .i_code (code_full),
        .o_kind (code_kind)
    );

    // Signature position, folded back to the start if out of range.
    assign sig_pos  = (r_sig_idx < 5'(SigLen)) ? r_sig_idx : 5'd0;
    assign sig_next = sig_pos + 5'd1;

    // Little-endian assembly: each byte enters at the top.
    assign shift_in = {i_byte, r_shift[63:8]};
    assign left_dec = (r_left != 4'd0) ? r_left - 4'd1 : 4'd0;
    assign num_kind = (r_pend < KIND_FLT || r_pend > KIND_I64) ? KIND_I64 : r_pend;

    // Right-align the assembled value and sign-extend the shorter integers.
    always_comb begin
        case (kind_len(r_pend))
            4'd2:    num_val = {{48{shift_in[63]}}, shift_in[63:48]};
            4'd4:    num_val = {{32{shift_in[63]}}, shift_in[63:32]};
            default: num_val = shift_in;
        endcase
    end

    // Next state and result for the byte at hand.
    always_comb begin
        logic clear;
        clear       = 1'b0;
        n_phase     = r_phase;
        n_sig_idx   = r_sig_idx;
        n_code      = r_code;
        n_shift     = r_shift;
        n_left      = r_left;
        n_pend      = r_pend;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (r_phase)
            PH_SIG: begin
                if (i_byte == sig_byte(sig_pos)) begin
                    n_sig_idx = sig_next;
                    if (sig_next == 5'(SigLen)) begin
                        n_phase = PH_CLO;
                    end
                    if (i_eoi) begin
                        o_res_valid      = 1'b1;
                        o_res.value_kind = KIND_STAT;
                        o_res.status     = (sig_next == 5'(SigLen)) ? ST_OK : ST_NOT_BIN;
                        o_res.stream_end = 1'b1;
                        clear            = 1'b1;
                    end
                end else begin
                    o_res_valid      = 1'b1;
                    o_res.value_kind = KIND_STAT;
                    o_res.status     = ST_NOT_BIN;
                    o_res.stream_end = 1'b1;
                    if (i_eoi) begin
                        clear = 1'b1;
                    end else begin
                        n_phase = PH_DRAIN;
                    end
                end
            end
            PH_CLO: begin
                n_code  = {8'd0, i_byte};
                n_phase = PH_CHI;
                if (i_eoi) begin
                    o_res_valid      = 1'b1;
                    o_res.value_kind = KIND_STAT;
                    o_res.status     = ST_OK;
                    o_res.stream_end = 1'b1;
                    clear            = 1'b1;
                end
            end
            PH_CHI: begin
                n_code = code_full;
                if (code_kind == KIND_STAT) begin
                    o_res_valid      = 1'b1;
                    o_res.group_code = $signed(code_full);
                    o_res.value_kind = KIND_STAT;
                    o_res.status     = ST_UNKNOWN;
                    o_res.stream_end = 1'b1;
                    if (i_eoi) begin
                        clear = 1'b1;
                    end else begin
                        n_phase = PH_DRAIN;
                    end
                end else begin
                    n_pend  = code_kind;
                    n_shift = '0;
                    if (code_kind == KIND_TEXT) begin
                        n_phase = PH_TEXT;
                        n_left  = 4'd0;
                    end else begin
                        n_phase = PH_NUM;
                        n_left  = kind_len(code_kind);
                    end
                    if (i_eoi) begin
                        o_res_valid      = 1'b1;
                        o_res.group_code = $signed(code_full);
                        o_res.value_kind = KIND_STAT;
                        o_res.status     = (code_kind == KIND_TEXT) ? ST_UNTERM : ST_TRUNC;
                        o_res.stream_end = 1'b1;
                        clear            = 1'b1;
                    end
                end
            end
            PH_TEXT: begin
                o_res_valid      = 1'b1;
                o_res.group_code = $signed(r_code);
                if (i_byte == 8'd0) begin
                    o_res.value_kind = KIND_TEND;
                    o_res.pair_done  = 1'b1;
                    o_res.stream_end = i_eoi;
                    if (i_eoi) begin
                        clear = 1'b1;
                    end else begin
                        n_phase = PH_CLO;
                    end
                end else if (i_eoi) begin
                    o_res.value_kind = KIND_STAT;
                    o_res.status     = ST_UNTERM;
                    o_res.stream_end = 1'b1;
                    clear            = 1'b1;
                end else begin
                    o_res.value_kind = KIND_TEXT;
                    o_res.text_byte  = i_byte;
                end
            end
            PH_NUM: begin
                n_shift = shift_in;
                n_left  = left_dec;
                if (left_dec == 4'd0) begin
                    o_res_valid      = 1'b1;
                    o_res.group_code = $signed(r_code);
                    o_res.value_kind = num_kind;
                    o_res.value_bits = num_val;
                    o_res.pair_done  = 1'b1;
                    o_res.stream_end = i_eoi;
                    if (i_eoi) begin
                        clear = 1'b1;
                    end else begin
                        n_phase = PH_CLO;
                    end
                end else if (i_eoi) begin
                    o_res_valid      = 1'b1;
                    o_res.group_code = $signed(r_code);
                    o_res.value_kind = KIND_STAT;
                    o_res.status     = ST_TRUNC;
                    o_res.stream_end = 1'b1;
                    clear            = 1'b1;
                end
            end
            default: begin
                if (i_eoi) begin
                    clear = 1'b1;
                end
            end
        endcase

        // Any end of file returns the decoder to its reset state.
        if (clear) begin
            n_phase   = PH_SIG;
            n_sig_idx = '0;
            n_code    = '0;
            n_shift   = '0;
            n_left    = '0;
            n_pend    = '0;
        end
    end

    // State registers, updated once per byte taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIG;
            r_sig_idx <= '0;
            r_code    <= '0;
            r_shift   <= '0;
            r_left    <= '0;
            r_pend    <= '0;
        end else if (i_adv) begin
            r_phase   <= n_phase;
            r_sig_idx <= n_sig_idx;
            r_code    <= n_code;
            r_shift   <= n_shift;
            r_left    <= n_left;
            r_pend    <= n_pend;
        end
    end

endmodule

`default_nettype wire
